[rtl/tgd_pkg.sv]
// Shared types and constants for the touch gesture detector.
// Used by tgd_evt_fifo and touch_gesture_detector; depends on nothing.
`default_nettype none

package tgd_pkg;

   // Touch points handled (2..4); point fields are fixed at 2 bits.
   localparam int NUM_POINTS = 4;
   localparam int PT_W       = 2;
   localparam int NUM_PAIRS  = 6;
   localparam int TIME_W     = 32;
   localparam int THR_W      = 16;
   localparam int CSR_IDX_W  = 4;

   // index of the last point the engine visits
   localparam logic [PT_W-1:0] PT_LAST = PT_W'(NUM_POINTS - 1);

   localparam logic [THR_W-1:0] LONG_PRESS_RST   = THR_W'(600);
   localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = THR_W'(300);

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_CLICK = CSR_IDX_W'(1);

   // Combo pairs, checked in order AB, AC, BC, AD, BD, CD.
   localparam logic [PT_W-1:0] PAIR_LO [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
   localparam logic [PT_W-1:0] PAIR_HI [NUM_PAIRS] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

   localparam int EVT_FIFO_DEPTH = 16;
   localparam int EVT_PTR_W      = $clog2(EVT_FIFO_DEPTH);
   localparam int EVT_CNT_W      = EVT_PTR_W + 1;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESSED = 2'd1,
      PH_HELD    = 2'd2,
      PH_WAIT    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      EV_SINGLE  = 3'd0,
      EV_DOUBLE  = 3'd1,
      EV_LONG    = 3'd2,
      EV_RELEASE = 3'd3,
      EV_COMBO   = 3'd4
   } evt_kind_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_COMBO,
      ENG_EVAL,
      ENG_SECOND
   } eng_state_type;

   // Per-point record held in the state memory.
   typedef struct packed {
      phase_type           phase;
      logic                long_rep;
      logic [TIME_W-1:0]   press_start;
      logic [TIME_W-1:0]   release_at;
   } point_rec_type;

   // One event word as queued toward the result channel.
   typedef struct packed {
      evt_kind_type        kind;
      logic [PT_W-1:0]     first;
      logic [PT_W-1:0]     second;
      logic                last;
   } evt_type;

endpackage

`default_nettype wire

[rtl/tgd_evt_fifo.sv]
// Event queue between the gesture engine and the result channel.
// Uses tgd_pkg for the event word type and depth.
`default_nettype none

module tgd_evt_fifo (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   input  wire tgd_pkg::evt_type push_word,
   output logic                 full,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output tgd_pkg::evt_type     out_word
);

   tgd_pkg::evt_type                 store [tgd_pkg::EVT_FIFO_DEPTH];
   logic [tgd_pkg::EVT_PTR_W-1:0]    wr_ptr_ff;
   logic [tgd_pkg::EVT_PTR_W-1:0]    rd_ptr_ff;
   logic [tgd_pkg::EVT_CNT_W-1:0]    count_ff;   // words in the store
   logic [tgd_pkg::EVT_CNT_W-1:0]    count_in;
   logic                             head_valid_ff;
   tgd_pkg::evt_type                 head_ff;
   logic                             pop;
   logic                             load;

   assign full      = (count_ff == tgd_pkg::EVT_CNT_W'(tgd_pkg::EVT_FIFO_DEPTH));
   assign out_valid = head_valid_ff;
   assign out_word  = head_ff;
   assign pop       = head_valid_ff && out_ready;
   // head register refills from the store when empty or being taken
   assign load      = (count_ff != '0) && (!head_valid_ff || out_ready);

   always_comb begin
      count_in = count_ff;
      if (push_valid && !load) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && load) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (load) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         if (load) begin
            head_valid_ff <= 1'b1;
         end else if (pop) begin
            head_valid_ff <= 1'b0;
         end
      end
   end

   // read and write never hit the same entry: a read needs a stored word
   always_ff @(posedge clock) begin
      if (push_valid) begin
         store[wr_ptr_ff] <= push_word;
      end
      if (load) begin
         head_ff <= store[rd_ptr_ff];
      end
   end

endmodule

`default_nettype wire

[rtl/touch_gesture_detector.sv]
// Touch gesture detector top level: input buffer, gesture engine, point state memory.
// Uses tgd_pkg and tgd_evt_fifo.
`default_nettype none

// Each req word is one scan tick (timestamp, touch levels, debounced active
// mask). The tick yields zero or more rsp words: pair combo events first (AB,
// AC, BC, AD, BD, CD), then click events per point in point order; tlast marks
// the final word of a tick, and a tick with no events yields no word. Per-point
// state lives in a 4-entry memory with a registered read; the engine reads a
// point, evaluates it and writes it back while reading the next point. A tick
// takes the engine through a combo step per combo event, an evaluation per
// point (P = 4) and an extra step per single click for its release word. A
// one-word input buffer takes the next tick while the current one is worked
// on, and a 16-word event queue with a registered head decouples the result
// channel; the engine pauses only while that queue is full. Registers (csr_index
// 0 long press ms, 1 double click ms) are to be written by the user only while
// idle; the block does not enforce it. Other indexes are ignored. No clearing
// pass after reset: per-entry valid bits make untouched points read as idle.

module touch_gesture_detector (
   input  wire logic        clock,
   input  wire logic        reset,
   // scan tick input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [31:0] now_ms, [35:32] touch_levels, [39:36] active_mask
   // event output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [1:0] first_point, [3:2] second_point, [7:4] zero
   output logic [2:0]       rsp_tuser,   // [2:0] evt_kind
   output logic             rsp_tlast,   // last_event
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // ---------------- configuration ----------------
   logic [tgd_pkg::THR_W-1:0] long_ff;
   logic [tgd_pkg::THR_W-1:0] dbl_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff <= tgd_pkg::LONG_PRESS_RST;
         dbl_ff  <= tgd_pkg::DOUBLE_CLICK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tgd_pkg::CSR_LONG_PRESS:   long_ff <= csr_wdata;
            tgd_pkg::CSR_DOUBLE_CLICK: dbl_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- input buffer ----------------
   logic                        in_valid_ff;
   logic [tgd_pkg::TIME_W-1:0]  in_now_ff;
   logic [3:0]                  in_lvl_ff;
   logic [3:0]                  in_act_ff;
   logic                        in_take;
   logic                        adv;      // engine may step (queue has room)
   logic                        fifo_full;

   assign adv        = !fifo_full;
   assign req_tready = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (in_take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_now_ff <= req_tdata[31:0];
         in_lvl_ff <= req_tdata[35:32];
         in_act_ff <= req_tdata[39:36];
      end
   end

   // ---------------- engine registers ----------------
   tgd_pkg::eng_state_type      state_ff, state_in;
   logic [tgd_pkg::PT_W-1:0]    pt_idx_ff, pt_idx_in;
   logic [tgd_pkg::TIME_W-1:0]  now_ff;
   logic [3:0]                  lvl_ff;
   logic [3:0]                  prev_act_ff;
   logic [tgd_pkg::NUM_PAIRS-1:0] combo_ff, combo_in;
   tgd_pkg::evt_type            pend_ff, pend_in;
   logic                        pend_valid_ff, pend_valid_in;

   // ---------------- point state memory ----------------
   tgd_pkg::point_rec_type      point_mem [tgd_pkg::NUM_POINTS];
   logic [tgd_pkg::NUM_POINTS-1:0] pt_valid_ff;
   tgd_pkg::point_rec_type      rd_data_ff;
   logic                        rd_valid_ff;
   logic                        mem_re;
   logic [tgd_pkg::PT_W-1:0]    rd_addr;
   logic                        mem_we;
   tgd_pkg::point_rec_type      rec;
   tgd_pkg::point_rec_type      rec_next;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[pt_idx_ff] <= rec_next;
      end
      if (mem_re) begin
         rd_data_ff <= point_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            pt_valid_ff[pt_idx_ff] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= pt_valid_ff[rd_addr];
         end
      end
   end

   // never-written entry reads as the reset record (idle, times zero)
   assign rec = rd_valid_ff ? rd_data_ff : '0;

   // ---------------- combo detection ----------------
   logic [tgd_pkg::NUM_PAIRS-1:0] combo_hits;
   logic [2:0]                    combo_sel;

   always_comb begin
      for (int p = 0; p < tgd_pkg::NUM_PAIRS; p++) begin
         combo_hits[p] = (int'(tgd_pkg::PAIR_HI[p]) < tgd_pkg::NUM_POINTS)
                      && in_act_ff[tgd_pkg::PAIR_LO[p]] && in_act_ff[tgd_pkg::PAIR_HI[p]]
                      && !(prev_act_ff[tgd_pkg::PAIR_LO[p]] && prev_act_ff[tgd_pkg::PAIR_HI[p]]);
      end
   end

   // lowest pending pair
   always_comb begin
      combo_sel = '0;
      for (int p = tgd_pkg::NUM_PAIRS - 1; p >= 0; p--) begin
         if (combo_ff[p]) begin
            combo_sel = 3'(p);
         end
      end
   end

   // ---------------- point evaluation ----------------
   logic                        cur;
   logic [tgd_pkg::TIME_W-1:0]  elapsed;
   logic                        ge_long;
   logic                        gt_dbl;
   logic                        pt_ev;
   tgd_pkg::evt_kind_type       pt_kind;
   logic                        two_ev;   // single click then release

   assign cur = lvl_ff[pt_idx_ff];
   // one subtractor: the wait phase measures from release, the rest from press
   assign elapsed = now_ff - ((rec.phase == tgd_pkg::PH_WAIT) ? rec.release_at
                                                              : rec.press_start);
   assign ge_long = (elapsed >= {{(tgd_pkg::TIME_W - tgd_pkg::THR_W){1'b0}}, long_ff});
   assign gt_dbl  = (elapsed >  {{(tgd_pkg::TIME_W - tgd_pkg::THR_W){1'b0}}, dbl_ff});

   always_comb begin
      rec_next = rec;
      pt_ev    = 1'b0;
      pt_kind  = tgd_pkg::EV_RELEASE;
      two_ev   = 1'b0;
      case (rec.phase)
         tgd_pkg::PH_IDLE: begin
            rec_next.long_rep = 1'b0;
            if (cur) begin
               rec_next.phase       = tgd_pkg::PH_PRESSED;
               rec_next.press_start = now_ff;
            end
         end
         tgd_pkg::PH_PRESSED: begin
            if (!cur) begin
               if (ge_long) begin
                  // long press ended before it was reported: release only
                  pt_ev          = 1'b1;
                  pt_kind        = tgd_pkg::EV_RELEASE;
                  rec_next.phase = tgd_pkg::PH_IDLE;
               end else begin
                  rec_next.phase      = tgd_pkg::PH_WAIT;
                  rec_next.release_at = now_ff;
               end
            end else if (ge_long && !rec.long_rep) begin
               pt_ev             = 1'b1;
               pt_kind           = tgd_pkg::EV_LONG;
               rec_next.long_rep = 1'b1;
               rec_next.phase    = tgd_pkg::PH_HELD;
            end
         end
         tgd_pkg::PH_HELD: begin
            if (!cur) begin
               pt_ev          = 1'b1;
               pt_kind        = tgd_pkg::EV_RELEASE;
               rec_next.phase = tgd_pkg::PH_IDLE;
            end
         end
         tgd_pkg::PH_WAIT: begin
            if (cur) begin
               pt_ev                = 1'b1;
               pt_kind              = tgd_pkg::EV_DOUBLE;
               rec_next.phase       = tgd_pkg::PH_PRESSED;
               rec_next.press_start = now_ff;
            end else if (gt_dbl) begin
               pt_ev          = 1'b1;
               pt_kind        = tgd_pkg::EV_SINGLE;
               two_ev         = 1'b1;
               rec_next.phase = tgd_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
   end

   // ---------------- engine: next state ----------------
   always_comb begin
      state_in = state_ff;
      if (adv) begin
         case (state_ff)
            tgd_pkg::ENG_IDLE: begin
               if (in_valid_ff) begin
                  state_in = tgd_pkg::ENG_COMBO;
               end
            end
            tgd_pkg::ENG_COMBO: begin
               if (combo_ff == '0) begin
                  state_in = tgd_pkg::ENG_EVAL;
               end
            end
            tgd_pkg::ENG_EVAL: begin
               if (two_ev) begin
                  state_in = tgd_pkg::ENG_SECOND;
               end else if (pt_idx_ff == tgd_pkg::PT_LAST) begin
                  state_in = tgd_pkg::ENG_IDLE;
               end
            end
            tgd_pkg::ENG_SECOND: begin
               state_in = (pt_idx_ff == tgd_pkg::PT_LAST) ? tgd_pkg::ENG_IDLE
                                                          : tgd_pkg::ENG_EVAL;
            end
            default: state_in = tgd_pkg::ENG_IDLE;
         endcase
      end
   end

   // ---------------- engine: outputs ----------------
   logic             new_ev;
   tgd_pkg::evt_type new_word;
   logic             push_en;
   tgd_pkg::evt_type push_word;

   always_comb begin
      in_take   = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      rd_addr   = pt_idx_ff;
      pt_idx_in = pt_idx_ff;
      combo_in  = combo_ff;
      new_ev    = 1'b0;
      new_word  = '{kind: tgd_pkg::EV_COMBO, first: pt_idx_ff, second: pt_idx_ff, last: 1'b0};
      if (adv) begin
         case (state_ff)
            tgd_pkg::ENG_IDLE: begin
               in_take  = in_valid_ff;
               combo_in = combo_hits;
            end
            tgd_pkg::ENG_COMBO: begin
               if (combo_ff != '0) begin
                  new_ev              = 1'b1;
                  new_word.first      = tgd_pkg::PAIR_LO[combo_sel];
                  new_word.second     = tgd_pkg::PAIR_HI[combo_sel];
                  combo_in[combo_sel] = 1'b0;
               end else begin
                  mem_re    = 1'b1;
                  rd_addr   = '0;
                  pt_idx_in = '0;
               end
            end
            tgd_pkg::ENG_EVAL: begin
               mem_we        = 1'b1;
               new_ev        = pt_ev;
               new_word.kind = pt_kind;
               if (!two_ev && pt_idx_ff != tgd_pkg::PT_LAST) begin
                  mem_re    = 1'b1;
                  rd_addr   = pt_idx_ff + 1'b1;
                  pt_idx_in = pt_idx_ff + 1'b1;
               end
            end
            tgd_pkg::ENG_SECOND: begin
               new_ev        = 1'b1;
               new_word.kind = tgd_pkg::EV_RELEASE;
               if (pt_idx_ff != tgd_pkg::PT_LAST) begin
                  mem_re    = 1'b1;
                  rd_addr   = pt_idx_ff + 1'b1;
                  pt_idx_in = pt_idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // One event is held back so the final event of a tick can carry tlast:
   // a new event pushes the held one as not-last; idle flushes it as last.
   always_comb begin
      push_en       = adv && pend_valid_ff && (new_ev || state_ff == tgd_pkg::ENG_IDLE);
      push_word     = pend_ff;
      push_word.last = (state_ff == tgd_pkg::ENG_IDLE);
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (adv) begin
         if (new_ev) begin
            pend_in       = new_word;
            pend_valid_in = 1'b1;
         end else if (state_ff == tgd_pkg::ENG_IDLE) begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tgd_pkg::ENG_IDLE;
         pt_idx_ff     <= '0;
         combo_ff      <= '0;
         prev_act_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pt_idx_ff     <= pt_idx_in;
         combo_ff      <= combo_in;
         pend_valid_ff <= pend_valid_in;
         if (in_take) begin
            prev_act_ff <= in_act_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (in_take) begin
         now_ff <= in_now_ff;
         lvl_ff <= in_lvl_ff;
      end
   end

   // ---------------- event queue ----------------
   tgd_pkg::evt_type out_word;

   tgd_evt_fifo u_evt_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_en),
      .push_word  (push_word),
      .full       (fifo_full),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

   assign rsp_tdata = {4'b0000, out_word.second, out_word.first};
   assign rsp_tuser = out_word.kind;
   assign rsp_tlast = out_word.last;

`ifndef SYNTHESIS
   // the release half of a single click follows only its evaluation step
   a_second_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tgd_pkg::ENG_SECOND && $past(state_ff) != tgd_pkg::ENG_SECOND)
         |-> $past(state_ff) == tgd_pkg::ENG_EVAL)
      else $error("second event step entered without evaluation");

   // no event word is pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !fifo_full)
      else $error("event pushed into full queue");

   // starting a tick leaves nothing held back from the previous one
   a_tick_start_clean: assert property (@(posedge clock) disable iff (reset)
      in_take |=> (state_ff == tgd_pkg::ENG_COMBO && !pend_valid_ff))
      else $error("tick started with a held event");
`endif

endmodule

`default_nettype wire
